### rtl/spht_pkg.sv
// Shared types, constants and register map for the span pick hit-test block.
// Used by the interfaces and every module of the block.
package spht_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DEPTH_W     = 32;
  localparam int FACE_W      = 24;
  localparam int MESH_W      = 8;
  localparam int SLOT_FW     = 4;
  localparam int CMD_W       = 2;
  localparam int POINT_SLOTS = 16;
  localparam int SLOT_IW     = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
  localparam int PROD_W      = COORD_BITS + DEPTH_W;
  localparam int CNT_W       = $clog2(PROD_W + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  // queue depth must stay a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPAN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_CIRCLE = 2'd1;
  localparam logic [1:0] MODE_RECT   = 2'd2;
  localparam logic [1:0] MODE_ARRAY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEPTH_W-1:0]    depth_t;

  typedef enum logic [2:0] {
    K_BEGIN,
    K_LOAD,
    K_READ,
    K_POINT,
    K_CIRCLE,
    K_RECT,
    K_ARRAY
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    coord_t      pick_x;
    coord_t      pick_y;
    coord_t      corner_x;
    coord_t      corner_y;
    logic [15:0] circle_radius;
    logic        invert;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    coord_t              span_left;
    coord_t              span_right;
    coord_t              span_row;
    depth_t              depth_left;
    depth_t              depth_right;
    logic [FACE_W-1:0]   face_index;
    logic [MESH_W-1:0]   mesh_id;
    logic [SLOT_FW-1:0]  point_slot;
    coord_t              point_col;
    coord_t              point_row;
  } item_t;

endpackage

### rtl/spht_if.sv
// Channel interfaces of the span pick hit-test block: requests, results, config.
// Depends on spht_pkg.
interface spht_in_if import spht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  coord_t             span_left;
  coord_t             span_right;
  coord_t             span_row;
  depth_t             depth_left;
  depth_t             depth_right;
  logic [FACE_W-1:0]  face_index;
  logic [MESH_W-1:0]  mesh_id;
  logic [SLOT_FW-1:0] point_slot;
  coord_t             point_col;
  coord_t             point_row;

  modport source (output valid, command, span_left, span_right, span_row, depth_left,
                  depth_right, face_index, mesh_id, point_slot, point_col, point_row,
                  input ready);
  modport sink (input valid, command, span_left, span_right, span_row, depth_left,
                depth_right, face_index, mesh_id, point_slot, point_col, point_row,
                output ready);
endinterface

interface spht_out_if import spht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit_valid;
  logic [MESH_W-1:0] hit_mesh;
  logic [FACE_W-1:0] hit_face;
  depth_t            hit_depth;
  logic              mark_triangle;
  logic              mark_deselect;

  modport source (output valid, hit_valid, hit_mesh, hit_face, hit_depth, mark_triangle,
                  mark_deselect, input ready);
  modport sink (input valid, hit_valid, hit_mesh, hit_face, hit_depth, mark_triangle,
                mark_deselect, output ready);
endinterface

interface spht_cfg_if import spht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/span_pick_hit_test.sv
// Span pick hit-test, top level: configuration registers, front end, queue, back end.
// Depends on spht_pkg, spht_if, spht_front, spht_queue, spht_back.
//
// Usage: write the setup registers on cfg_i (mode, pick point, second rectangle
// corner, circle radius, invert) while no request is in flight; writes always
// complete in the cycle they are offered. Requests enter on in_i and every request
// returns exactly one result on out_o, in order.
// Begin, load, read and rectangle requests go straight from the queue to the result.
// A hitting span in point mode runs the bit-serial multiplier and the restoring
// divider; a zero-width hit skips both, and a span that misses the pick row or
// column goes straight to the result. In array mode the depth unit runs once per
// table slot and does the full depth work only for a slot that lies in the span.
// Circle spans square their distances, then compare them with the squared radius.
// The back end takes its next request only once its last result is registered.
// The front register and a two-entry queue keep accepting requests while the back
// end works; a result waits in the output register while the receiver stalls, and
// the back end holds its next result until that register frees.
// Reset clears the setup registers, the nearest hit (depth at the largest positive
// value) and every table hit; table coordinates are undefined until loaded.
module span_pick_hit_test import spht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  spht_cfg_if.sink    cfg_i,
  spht_in_if.sink     in_i,
  spht_out_if.source  out_o
);

  cfg_t  cfg_q;
  logic  q_ready, push, q_valid, q_pop;
  item_t fr_item, q_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_MODE:     cfg_q.mode          <= cfg_i.data[1:0];
        REG_PICK_X:   cfg_q.pick_x        <= cfg_i.data;
        REG_PICK_Y:   cfg_q.pick_y        <= cfg_i.data;
        REG_CORNER_X: cfg_q.corner_x      <= cfg_i.data;
        REG_CORNER_Y: cfg_q.corner_y      <= cfg_i.data;
        REG_RADIUS:   cfg_q.circle_radius <= cfg_i.data;
        REG_INVERT:   cfg_q.invert        <= cfg_i.data[0];
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  spht_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (cfg_q.mode),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (fr_item)
  );

  spht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  spht_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

### rtl/spht_front.sv
// Front end: accepts requests, classifies them by command and mode, registers them.
// Depends on spht_pkg and spht_in_if.
module spht_front import spht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  spht_in_if.sink    in_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output item_t      item_o
);

  logic  fr_valid_q;
  item_t fr_q;
  kind_e kind;

  assign in_i.ready = !fr_valid_q || q_ready_i;
  assign push_o     = fr_valid_q;
  assign item_o     = fr_q;

  always_comb begin
    kind = K_BEGIN;
    unique case (in_i.command)
      CMD_BEGIN: kind = K_BEGIN;
      CMD_LOAD:  kind = K_LOAD;
      CMD_READ:  kind = K_READ;
      CMD_SPAN: begin
        unique case (mode_i)
          MODE_POINT:  kind = K_POINT;
          MODE_CIRCLE: kind = K_CIRCLE;
          MODE_RECT:   kind = K_RECT;
          MODE_ARRAY:  kind = K_ARRAY;
          default:     kind = K_POINT;
        endcase
      end
      default: kind = K_BEGIN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      fr_valid_q <= 1'b1;
    end else if (q_ready_i) begin
      fr_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      fr_q.kind        <= kind;
      fr_q.span_left   <= in_i.span_left;
      fr_q.span_right  <= in_i.span_right;
      fr_q.span_row    <= in_i.span_row;
      fr_q.depth_left  <= in_i.depth_left;
      fr_q.depth_right <= in_i.depth_right;
      fr_q.face_index  <= in_i.face_index;
      fr_q.mesh_id     <= in_i.mesh_id;
      fr_q.point_slot  <= in_i.point_slot;
      fr_q.point_col   <= in_i.point_col;
      fr_q.point_row   <= in_i.point_row;
    end
  end

endmodule

### rtl/spht_queue.sv
// Short request queue between front and back end.
// Depends on spht_pkg.
module spht_queue import spht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

### rtl/spht_back.sv
// Back end: executes queued requests with a shift-add multiplier, a restoring
// divider, the point table and the output register. Depends on spht_pkg, spht_out_if.
module spht_back import spht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  spht_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_MUL, S_DIV, S_QUOT, S_CMP, S_CIRC_SQ, S_CIRC_CMP, S_RESULT
  } state_e;

  localparam int CW = COORD_BITS;

  state_e               state_q;
  item_t                it_q;
  logic [SLOT_IW-1:0]   idx_q;
  logic                 in_range_q;
  logic [CW-1:0]        a_q, d_q, rem_q;
  logic [PROD_W-1:0]    bsh_q, acc_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [DEPTH_W+1:0] z_q;
  logic [CW-1:0]        ax_q, ay_q;
  logic                 nonempty_q;
  logic [2*CW-1:0]      sqx_q, sqy_q;
  logic [31:0]          r2_q;
  logic                 mark_q;

  depth_t               best_depth_q;
  logic [MESH_W-1:0]    best_mesh_q;
  logic [FACE_W-1:0]    best_face_q;
  logic                 best_valid_q;

  coord_t               slot_col_q   [POINT_SLOTS];
  coord_t               slot_row_q   [POINT_SLOTS];
  depth_t               slot_depth_q [POINT_SLOTS];
  logic [MESH_W-1:0]    slot_mesh_q  [POINT_SLOTS];
  logic [FACE_W-1:0]    slot_face_q  [POINT_SLOTS];
  logic [POINT_SLOTS-1:0] slot_valid_q;

  logic                 out_valid_q, out_hit_valid_q, out_mark_q, out_desel_q;
  logic [MESH_W-1:0]    out_mesh_q;
  logic [FACE_W-1:0]    out_face_q;
  depth_t               out_depth_q;

  // target point and span tests
  coord_t               tgt_col, tgt_row;
  logic                 in_span, last_tgt;
  logic signed [CW:0]   a_w, d_w;
  logic signed [DEPTH_W:0] dz, dz_abs;
  logic [CW:0]          trial, trial_sub;
  logic                 ge;
  logic signed [DEPTH_W+1:0] q_s, z_w;
  depth_t               cur_depth;
  logic                 z_hit;
  // circle and rectangle setup from the queue head
  coord_t               clamp_p;
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        adx, ady;
  logic                 rect_ok, slot_ok;
  logic [SLOT_IW-1:0]   head_idx;
  logic [2*CW:0]        sq_sum;
  logic [2*CW+8:0]      lhs;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    tgt_col  = (it_q.kind == K_ARRAY) ? slot_col_q[idx_q] : cfg_i.pick_x;
    tgt_row  = (it_q.kind == K_ARRAY) ? slot_row_q[idx_q] : cfg_i.pick_y;
    in_span  = (tgt_row == it_q.span_row) &&
               ($signed(tgt_col) >= $signed(it_q.span_left)) &&
               ($signed(tgt_col) <= $signed(it_q.span_right));
    last_tgt = (it_q.kind != K_ARRAY) || (idx_q == SLOT_IW'(POINT_SLOTS - 1));
    a_w      = $signed({tgt_col[CW-1], tgt_col}) -
               $signed({it_q.span_left[CW-1], it_q.span_left});
    d_w      = $signed({it_q.span_right[CW-1], it_q.span_right}) -
               $signed({it_q.span_left[CW-1], it_q.span_left});
    dz       = $signed({it_q.depth_right[DEPTH_W-1], it_q.depth_right}) -
               $signed({it_q.depth_left[DEPTH_W-1], it_q.depth_left});
    dz_abs   = dz[DEPTH_W] ? -dz : dz;

    trial     = {rem_q, acc_q[PROD_W-1]};
    ge        = trial >= {1'b0, d_q};
    trial_sub = trial - {1'b0, d_q};

    q_s = neg_q ? -$signed({2'b00, acc_q[DEPTH_W-1:0]}) : $signed({2'b00, acc_q[DEPTH_W-1:0]});
    z_w = $signed({{2{it_q.depth_left[DEPTH_W-1]}}, it_q.depth_left}) + q_s;

    if (it_q.kind == K_POINT) cur_depth = best_depth_q;
    else cur_depth = slot_valid_q[idx_q] ? slot_depth_q[idx_q] : DEPTH_MAX;
    z_hit = !z_q[DEPTH_W+1] && (z_q != '0) &&
            (z_q < $signed({{2{cur_depth[DEPTH_W-1]}}, cur_depth}));

    if ($signed(cfg_i.pick_x) < $signed(q_item_i.span_left)) clamp_p = q_item_i.span_left;
    else if ($signed(cfg_i.pick_x) > $signed(q_item_i.span_right)) clamp_p = q_item_i.span_right;
    else clamp_p = cfg_i.pick_x;
    dx  = $signed({cfg_i.pick_x[CW-1], cfg_i.pick_x}) - $signed({clamp_p[CW-1], clamp_p});
    dy  = $signed({cfg_i.pick_y[CW-1], cfg_i.pick_y}) -
          $signed({q_item_i.span_row[CW-1], q_item_i.span_row});
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];

    rect_ok = !((($signed(q_item_i.span_left) < $signed(cfg_i.pick_x)) &&
                 ($signed(q_item_i.span_left) < $signed(cfg_i.corner_x))) ||
                (($signed(q_item_i.span_right) > $signed(cfg_i.pick_x)) &&
                 ($signed(q_item_i.span_right) > $signed(cfg_i.corner_x))) ||
                (($signed(q_item_i.span_row) < $signed(cfg_i.pick_y)) &&
                 ($signed(q_item_i.span_row) < $signed(cfg_i.corner_y))) ||
                (($signed(q_item_i.span_row) > $signed(cfg_i.pick_y)) &&
                 ($signed(q_item_i.span_row) > $signed(cfg_i.corner_y))) ||
                q_item_i.depth_left[DEPTH_W-1] || q_item_i.depth_right[DEPTH_W-1]);

    slot_ok  = 32'(q_item_i.point_slot) < POINT_SLOTS;
    head_idx = SLOT_IW'(q_item_i.point_slot);

    sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
    lhs    = {sq_sum, 8'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      best_depth_q <= DEPTH_MAX;
      best_mesh_q  <= '0;
      best_face_q  <= '0;
      best_valid_q <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_RESULT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q   <= q_item_i;
            mark_q <= (q_item_i.kind == K_RECT) && rect_ok;
            idx_q  <= (q_item_i.kind == K_READ) ? head_idx : '0;
            unique case (q_item_i.kind)
              K_BEGIN: begin
                best_depth_q <= DEPTH_MAX;
                best_mesh_q  <= '0;
                best_face_q  <= '0;
                best_valid_q <= 1'b0;
                slot_valid_q <= '0;
                state_q      <= S_RESULT;
              end
              K_LOAD: begin
                if (slot_ok) begin
                  slot_col_q[head_idx]   <= q_item_i.point_col;
                  slot_row_q[head_idx]   <= q_item_i.point_row;
                  slot_valid_q[head_idx] <= 1'b0;
                end
                state_q <= S_RESULT;
              end
              K_READ: begin
                in_range_q <= slot_ok;
                state_q    <= S_RESULT;
              end
              K_POINT, K_ARRAY: state_q <= S_SETUP;
              K_CIRCLE: begin
                ax_q       <= adx;
                ay_q       <= ady;
                nonempty_q <= $signed(q_item_i.span_left) <= $signed(q_item_i.span_right);
                state_q    <= S_CIRC_SQ;
              end
              default: state_q <= S_RESULT;
            endcase
          end
        end
        S_SETUP: begin
          if (!in_span) begin
            if (last_tgt) state_q <= S_RESULT;
            else idx_q <= idx_q + 1'b1;
          end else if (d_w == '0) begin
            z_q     <= $signed({{2{it_q.depth_left[DEPTH_W-1]}}, it_q.depth_left});
            state_q <= S_CMP;
          end else begin
            a_q     <= a_w[CW-1:0];
            d_q     <= d_w[CW-1:0];
            bsh_q   <= PROD_W'(dz_abs[DEPTH_W-1:0]);
            neg_q   <= dz[DEPTH_W];
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // one multiplier bit a cycle
          if (a_q[0]) acc_q <= acc_q + bsh_q;
          bsh_q <= {bsh_q[PROD_W-2:0], 1'b0};
          a_q   <= {1'b0, a_q[CW-1:1]};
          if (cnt_q == CNT_W'(CW - 1)) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          // one quotient bit a cycle; quotient shifts into acc
          rem_q <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
          acc_q <= {acc_q[PROD_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(PROD_W - 1)) state_q <= S_QUOT;
        end
        S_QUOT: begin
          z_q     <= z_w;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (z_hit) begin
            if (it_q.kind == K_POINT) begin
              best_depth_q <= z_q[DEPTH_W-1:0];
              best_mesh_q  <= it_q.mesh_id;
              best_face_q  <= it_q.face_index;
              best_valid_q <= 1'b1;
            end else begin
              slot_depth_q[idx_q] <= z_q[DEPTH_W-1:0];
              slot_mesh_q[idx_q]  <= it_q.mesh_id;
              slot_face_q[idx_q]  <= it_q.face_index;
              slot_valid_q[idx_q] <= 1'b1;
            end
          end
          if (last_tgt) state_q <= S_RESULT;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SETUP;
          end
        end
        S_CIRC_SQ: begin
          sqx_q   <= ax_q * ax_q;
          sqy_q   <= ay_q * ay_q;
          r2_q    <= cfg_i.circle_radius * cfg_i.circle_radius;
          state_q <= S_CIRC_CMP;
        end
        S_CIRC_CMP: begin
          mark_q  <= nonempty_q && (lhs < (2*CW+9)'(r2_q));
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_mark_q  <= mark_q;
            out_desel_q <= mark_q && cfg_i.invert;
            if (it_q.kind == K_READ) begin
              if (in_range_q && slot_valid_q[idx_q]) begin
                out_hit_valid_q <= 1'b1;
                out_mesh_q      <= slot_mesh_q[idx_q];
                out_face_q      <= slot_face_q[idx_q];
                out_depth_q     <= slot_depth_q[idx_q];
              end else begin
                out_hit_valid_q <= 1'b0;
                out_mesh_q      <= '0;
                out_face_q      <= '0;
                out_depth_q     <= DEPTH_MAX;
              end
            end else begin
              out_hit_valid_q <= best_valid_q;
              out_mesh_q      <= best_mesh_q;
              out_face_q      <= best_face_q;
              out_depth_q     <= best_depth_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit_valid     = out_hit_valid_q;
  assign out_o.hit_mesh      = out_mesh_q;
  assign out_o.hit_face      = out_face_q;
  assign out_o.hit_depth     = out_depth_q;
  assign out_o.mark_triangle = out_mark_q;
  assign out_o.mark_deselect = out_desel_q;

endmodule
